// ----- hdl/psc_pkg.sv -----
// psc_pkg: shared types, signature table and header codes for the payload
// signature classifier. No dependencies; used by every module under hdl.
package psc_pkg;

	localparam int SIG_COUNT   = 9;
	localparam int SIG_MAXB    = 23;
	localparam int POS_W       = 6;
	localparam int LEN_W       = POS_W + 1;
	localparam int TAB_IDX_W   = 5;
	localparam int IDX_W       = 4;
	localparam int DEF_MAX_LEN = 32;

	localparam logic [7:0] HDR_E9 = 8'hE9;
	localparam logic [7:0] HDR_E1 = 8'hE1;
	localparam logic [7:0] HDR_E2 = 8'hE2;

	localparam logic [15:0] FC_FLASH   = 16'hE90E;
	localparam logic [15:0] FC_SPARKLE = 16'hE910;
	localparam logic [15:0] FC_CIRCLE  = 16'hE912;
	localparam logic [15:0] FC_PULSE   = 16'hE913;
	localparam logic [15:0] FC_FADE    = 16'hE911;

	localparam logic [IDX_W-1:0] IDX_FLASH   = 4'd3;
	localparam logic [IDX_W-1:0] IDX_SPARKLE = 4'd4;
	localparam logic [IDX_W-1:0] IDX_PULSE   = 4'd5;
	localparam logic [IDX_W-1:0] IDX_CIRCLE  = 4'd6;
	localparam logic [IDX_W-1:0] IDX_FADE    = 4'd7;

	typedef enum logic [1:0] {
		Q_NONE  = 2'd0,
		Q_EXACT = 2'd1,
		Q_FUZZY = 2'd2
	} quality_t;

	localparam logic [TAB_IDX_W-1:0] SIG_LEN [SIG_COUNT] = '{
		5'd16, 5'd16, 5'd16, 5'd18, 5'd20, 5'd23, 5'd22, 5'd21, 5'd21
	};

	localparam logic [7:0] SIG_TAB [SIG_COUNT][SIG_MAXB] = '{
		'{8'hE1,8'h00,8'hE9,8'h0C,8'h00,8'h0F,8'h0F,8'h5D,8'h46,8'h5B,8'hF0,8'h05,
		  8'h32,8'h37,8'h48,8'hB0,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h0C,8'h00,8'h0F,8'h0F,8'h5D,8'h46,8'h5B,8'hF0,8'h05,
		  8'h32,8'h37,8'h48,8'h95,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h0C,8'h00,8'h0F,8'h0F,8'hB1,8'hB9,8'hB5,8'hB1,8'hA2,
		  8'h30,8'h7B,8'h7D,8'hB0,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h0E,8'h00,8'h01,8'h0F,8'hBD,8'hA0,8'hA0,8'hBD,8'hA0,
		  8'h59,8'h07,8'h00,8'h48,8'hAE,8'hB5,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h10,8'h00,8'h13,8'h48,8'h97,8'hD0,8'h0E,8'hA0,8'hD1,
		  8'h46,8'h06,8'h0F,8'h30,8'hD0,8'h4E,8'h07,8'hB0,8'h00,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h13,8'h00,8'h02,8'hD0,8'h37,8'hF0,8'hD2,8'h3D,8'h05,
		  8'h05,8'h00,8'h0E,8'hFA,8'h89,8'h83,8'h51,8'h0E,8'hE7,8'hA0,8'hB0},
		'{8'hE2,8'h00,8'hE9,8'h12,8'h00,8'h03,8'h0F,8'hA2,8'hA2,8'hA4,8'hA4,8'hA2,
		  8'h30,8'hD0,8'h37,8'hF4,8'hD2,8'h46,8'h00,8'h64,8'hFC,8'hB8,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h11,8'h00,8'h6F,8'h0F,8'h56,8'h48,8'h58,8'hF4,8'h48,
		  8'h82,8'hD1,8'h46,8'h02,8'h08,8'hD0,8'h65,8'h00,8'hB0,8'h00,8'h00},
		'{8'hE1,8'h00,8'hE9,8'h11,8'h00,8'h0F,8'h0F,8'h48,8'h59,8'h58,8'hF4,8'h48,
		  8'h82,8'hD1,8'h46,8'h02,8'h0D,8'hD0,8'h65,8'h05,8'hB0,8'h00,8'h00}
	};

	// what the tracker knows about a payload at its final byte
	typedef struct packed {
		logic             exact;
		logic [IDX_W-1:0] exact_idx;
		logic             len_ge2;
		logic             len_ge4;
		logic [31:0]      head;
	} track_res_t;

endpackage

// ----- hdl/psc_track.sv -----
// psc_track: per-payload state (position, alive masks, header bytes) and the
// exact signature match. Depends on psc_pkg.
module psc_track #(
	parameter int MAX_LEN = psc_pkg::DEF_MAX_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output psc_pkg::track_res_t  res
);
	import psc_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
	localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_LEN + 1);

	logic [POS_W-1:0]     pos_q;
	logic [SIG_COUNT-1:0] full_q;
	logic [SIG_COUNT-1:0] inner_q;
	logic [31:0]          head_q;

	logic [POS_W-1:0]     pos_nxt;
	logic [SIG_COUNT-1:0] full_nxt;
	logic [SIG_COUNT-1:0] inner_nxt;
	logic [31:0]          head_nxt;
	logic                 over;
	logic [LEN_W-1:0]     len;
	logic [LEN_W-1:0]     pos_p2;

	assign over   = (pos_q >= POS_MAX);
	assign len    = over ? LEN_OVER : ({1'b0, pos_q} + LEN_W'(1));
	assign pos_p2 = {1'b0, pos_q} + LEN_W'(2);

	// each signature compares this byte in both alignments at once
	always_comb begin
		full_nxt  = full_q;
		inner_nxt = inner_q;
		for (int i = 0; i < SIG_COUNT; i++) begin
			if (over || pos_q >= POS_W'(SIG_LEN[i]) ||
			    SIG_TAB[i][pos_q[TAB_IDX_W-1:0]] != data_byte) begin
				full_nxt[i] = 1'b0;
			end
			if (over || pos_p2 >= LEN_W'(SIG_LEN[i]) ||
			    SIG_TAB[i][pos_p2[TAB_IDX_W-1:0]] != data_byte) begin
				inner_nxt[i] = 1'b0;
			end
		end
	end

	always_comb begin
		head_nxt = head_q;
		if (pos_q < POS_W'(4)) begin
			head_nxt[{pos_q[1:0], 3'b000} +: 8] = data_byte;
		end
		pos_nxt = over ? pos_q : pos_q + POS_W'(1);
	end

	// first table entry wins
	always_comb begin
		res.exact     = 1'b0;
		res.exact_idx = '0;
		for (int i = SIG_COUNT - 1; i >= 0; i--) begin
			if ((full_nxt[i] && len == LEN_W'(SIG_LEN[i])) ||
			    (inner_nxt[i] && len + LEN_W'(2) == LEN_W'(SIG_LEN[i]))) begin
				res.exact     = 1'b1;
				res.exact_idx = IDX_W'(i);
			end
		end
		res.len_ge2 = (len >= LEN_W'(2));
		res.len_ge4 = (len >= LEN_W'(4));
		res.head    = head_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			full_q  <= '1;
			inner_q <= '1;
			head_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q   <= '0;
				full_q  <= '1;
				inner_q <= '1;
				head_q  <= '0;
			end else begin
				pos_q   <= pos_nxt;
				full_q  <= full_nxt;
				inner_q <= inner_nxt;
				head_q  <= head_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond saturation");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> pos_q == '0 && full_q == '1 && inner_q == '1 && head_q == '0)
		else $error("state not cleared after final byte");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pos_q) && $stable(full_q) && $stable(inner_q))
		else $error("state moved without an item");

	a_exact_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.exact |-> !over)
		else $error("exact match on an overlong payload");
`endif

endmodule

// ----- hdl/psc_decode.sv -----
// psc_decode: function code from the header bytes and the final
// classification (exact, fuzzy by code, none). Depends on psc_pkg.
module psc_decode (
	input  psc_pkg::track_res_t      res,
	output psc_pkg::quality_t        quality,
	output logic [psc_pkg::IDX_W-1:0] index,
	output logic [15:0]              func
);
	import psc_pkg::*;

	logic [7:0] hb0;
	logic [7:0] hb1;
	logic [7:0] hb2;
	logic [7:0] hb3;

	assign hb0 = res.head[7:0];
	assign hb1 = res.head[15:8];
	assign hb2 = res.head[23:16];
	assign hb3 = res.head[31:24];

	always_comb begin
		if (res.len_ge4 && (hb0 == HDR_E1 || hb0 == HDR_E2) && hb2 == HDR_E9) begin
			func = {HDR_E9, hb3};
		end else if (res.len_ge2 && hb0 == HDR_E9) begin
			func = {HDR_E9, hb1};
		end else begin
			func = '0;
		end
	end

	always_comb begin
		quality = Q_NONE;
		index   = '0;
		if (res.exact) begin
			quality = Q_EXACT;
			index   = res.exact_idx;
		end else begin
			case (func)
				FC_FLASH: begin
					quality = Q_FUZZY;
					index   = IDX_FLASH;
				end
				FC_SPARKLE: begin
					quality = Q_FUZZY;
					index   = IDX_SPARKLE;
				end
				FC_CIRCLE: begin
					quality = Q_FUZZY;
					index   = IDX_CIRCLE;
				end
				FC_PULSE: begin
					quality = Q_FUZZY;
					index   = IDX_PULSE;
				end
				FC_FADE: begin
					quality = Q_FUZZY;
					index   = IDX_FADE;
				end
				default: begin
					quality = Q_NONE;
					index   = '0;
				end
			endcase
		end
	end

endmodule

// ----- hdl/payload_signature_classifier_top.sv -----
// payload_signature_classifier_top: input register, tracker, decoder and
// result register. Depends on psc_pkg, psc_track and psc_decode.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | data_byte, last_byte
//  out     | out_valid | out_stall | match_quality, preset_index, function_code
//
// one byte is taken every cycle while in_stall is low; a result is presented once its
// final byte has passed the input register and the result register
// arst_n clears position, alive masks, header bytes and both valid flags
// a held result stalls only a final byte; other bytes keep flowing behind it
module payload_signature_classifier_top #(
	parameter int MAX_LEN = psc_pkg::DEF_MAX_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  match_quality,
	output logic [psc_pkg::IDX_W-1:0]   preset_index,
	output logic [15:0]                 function_code
);
	import psc_pkg::*;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic             step;
	logic             in_acc;
	track_res_t       res;
	quality_t         quality;
	logic [IDX_W-1:0] index;
	logic [15:0]      func;
	logic             out_valid_q;
	quality_t         quality_q;
	logic [IDX_W-1:0] index_q;
	logic [15:0]      func_q;

	// a final byte waits only while the result register is full and held
	assign step     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	psc_track #(
		.MAX_LEN(MAX_LEN)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	psc_decode u_decode (
		.res     (res),
		.quality (quality),
		.index   (index),
		.func    (func)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			quality_q <= quality;
			index_q   <= index;
			func_q    <= func;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_quality = quality_q;
	assign preset_index  = index_q;
	assign function_code = func_q;

endmodule
